>>> rtl/kdlp_pkg.sv
// shared types, constants and helpers for the key debounce block
package kdlp_pkg;

  // timestamp arithmetic width, elapsed time wraps modulo 2^TimeBits
  localparam int TimeBits = 32;
  localparam int NowBits = 32;
  localparam int ThrBits = 16;
  localparam int CmpBits = (TimeBits > ThrBits) ? TimeBits : ThrBits;

  // configuration port
  localparam int CfgAddrBits = 2;
  localparam int CfgDataBits = 16;
  localparam logic [CfgAddrBits-1:0] CfgDebounce = 2'd0;
  localparam logic [CfgAddrBits-1:0] CfgLongPress = 2'd1;

  // reset values of the thresholds
  localparam logic [ThrBits-1:0] DebounceRst = 16'd20;
  localparam logic [ThrBits-1:0] LongPressRst = 16'd1000;

  // stream widths
  localparam int InDataBits = 40;
  localparam int OutDataBits = 8;

  // encoded scan state as reported on the output
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDebounce = 2'd1;
  localparam logic [1:0] StPressed = 2'd2;
  localparam logic [1:0] StRelease = 2'd3;

  typedef enum logic [3:0] {
    PhIdle     = 4'b0001,
    PhDebounce = 4'b0010,
    PhPressed  = 4'b0100,
    PhRelease  = 4'b1000
  } phase_e;

  // one scan request
  typedef struct packed {
    logic              key_level;
    logic [NowBits-1:0] now_ms;
  } scan_t;

  // one result
  typedef struct packed {
    logic       buzzer_on_pulse;
    logic       buzzer_off_pulse;
    logic       toggle_pulse;
    logic [1:0] scan_state;
    logic       long_seen;
  } result_t;

  // elapsed time reached a threshold
  function automatic logic reached(logic [TimeBits-1:0] elapsed,
                                   logic [ThrBits-1:0] thr);
    return CmpBits'(elapsed) >= CmpBits'(thr);
  endfunction

endpackage

>>> rtl/kdlp_core.sv
// input register, debounce state machine and per-scan step logic
module kdlp_core import kdlp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // scan requests
  input  logic                   scan_valid_i,
  output logic                   scan_ready_o,
  input  scan_t                  scan_i,
  // thresholds
  input  logic [ThrBits-1:0]     debounce_time_i,
  input  logic [ThrBits-1:0]     long_press_time_i,
  // results toward the output register
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output result_t                res_o
);

  logic                  in_valid_q;
  scan_t                 in_q;
  phase_e                phase_q, phase_d;
  logic [TimeBits-1:0]   mark_q, mark_d;
  logic                  long_q, long_d;
  logic                  advance;
  logic [TimeBits-1:0]   now_t;
  logic [TimeBits-1:0]   elapsed;
  logic                  released;
  logic                  dbc_hit;
  logic                  on_p, off_p, tog_p;

  assign advance      = in_valid_q & res_ready_i;
  assign scan_ready_o = ~in_valid_q | res_ready_i;
  assign res_valid_o  = in_valid_q;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (scan_ready_o) begin
      in_valid_q <= scan_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_ready_o && scan_valid_i) begin
      in_q <= scan_i;
    end
  end

  // elapsed time since the mark, wrapping
  assign released = in_q.key_level;
  assign now_t    = TimeBits'(in_q.now_ms);
  assign elapsed  = now_t - mark_q;
  assign dbc_hit  = reached(elapsed, debounce_time_i);

  // step logic
  always_comb begin
    phase_d = phase_q;
    mark_d  = mark_q;
    long_d  = long_q;
    on_p    = 1'b0;
    off_p   = 1'b0;
    tog_p   = 1'b0;
    unique case (phase_q)
      PhIdle: begin
        if (!released) begin
          phase_d = PhDebounce;
          mark_d  = now_t;
          long_d  = 1'b0;
        end
      end
      PhDebounce: begin
        if (dbc_hit) begin
          phase_d = released ? PhIdle : PhPressed;
        end
      end
      PhPressed: begin
        if (!long_q && reached(elapsed, long_press_time_i)) begin
          long_d = 1'b1;
          on_p   = 1'b1;
        end
        if (released) begin
          phase_d = PhRelease;
          mark_d  = now_t;
        end
      end
      PhRelease: begin
        if (dbc_hit) begin
          if (released) begin
            off_p   = 1'b1;
            tog_p   = ~long_q;
            phase_d = PhIdle;
          end else begin
            phase_d = PhPressed;
          end
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
  end

  // state registers, updated once per processed scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      mark_q  <= '0;
      long_q  <= 1'b0;
    end else if (advance) begin
      phase_q <= phase_d;
      mark_q  <= mark_d;
      long_q  <= long_d;
    end
  end

  // encode the next state for the result
  always_comb begin
    res_o.buzzer_on_pulse  = on_p;
    res_o.buzzer_off_pulse = off_p;
    res_o.toggle_pulse     = tog_p;
    res_o.long_seen        = long_d;
    unique case (phase_d)
      PhIdle:     res_o.scan_state = StIdle;
      PhDebounce: res_o.scan_state = StDebounce;
      PhPressed:  res_o.scan_state = StPressed;
      PhRelease:  res_o.scan_state = StRelease;
      default:    res_o.scan_state = StIdle;
    endcase
  end

endmodule

>>> rtl/kdlp_out_reg.sv
// result register that holds a result until the receiver takes it
module kdlp_out_reg import kdlp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_valid_i,
  output logic    res_ready_o,
  input  result_t res_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  logic    valid_q;
  result_t data_q;

  assign res_ready_o = ~valid_q | out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

endmodule

>>> rtl/key_debounce_long_press_top.sv
// Debouncer for one active-low key with click and long-press detection.
// Each request on the s_axis channel is one scan: the raw key level and the
// current millisecond timestamp. Every scan gives exactly one result on the
// m_axis channel: buzzer-on, buzzer-off and toggle pulses, the state after
// the scan (0 idle, 1 debounce, 2 pressed, 3 release) and the long-press flag.
// Thresholds are written through the cfg channel (index 0 debounce time,
// index 1 long-press time, in ms); write them only while no scan is in flight.
// A scan passes two registers on its way: the input register holds it while the
// step logic works out its result, and the result register, loaded from the
// step logic, holds that result and drives m_axis_tvalid.
// Throughput is one scan per cycle while the receiver does not stall; the state
// update is one subtract plus threshold compares between input and result registers.
// If the receiver stalls, the result register holds its result and the
// input register holds the next scan; s_axis_tready drops once both are full.
// Reset clears the state to idle, the mark time and long-press flag to zero,
// the thresholds to 20 ms and 1000 ms, and empties both registers.
module key_debounce_long_press_top import kdlp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // scan requests
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [InDataBits-1:0]  s_axis_tdata,   // key_level, now_ms[31:0], zero pad
  // results
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OutDataBits-1:0] m_axis_tdata,   // buzzer_on_pulse, buzzer_off_pulse,
                                                 // toggle_pulse, scan_state[1:0],
                                                 // long_seen, zero pad
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgAddrBits-1:0] cfg_addr_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  logic [ThrBits-1:0] debounce_q;
  logic [ThrBits-1:0] long_press_q;
  scan_t              scan;
  logic               res_valid;
  logic               res_ready;
  result_t            res;
  result_t            out;

  assign cfg_ready_o = 1'b1;

  // threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DebounceRst;
      long_press_q <= LongPressRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CfgDebounce:  debounce_q   <= ThrBits'(cfg_data_i);
        CfgLongPress: long_press_q <= ThrBits'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // unpack the scan request
  assign scan.key_level = s_axis_tdata[0];
  assign scan.now_ms    = s_axis_tdata[NowBits:1];

  kdlp_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .scan_valid_i      (s_axis_tvalid),
    .scan_ready_o      (s_axis_tready),
    .scan_i            (scan),
    .debounce_time_i   (debounce_q),
    .long_press_time_i (long_press_q),
    .res_valid_o       (res_valid),
    .res_ready_i       (res_ready),
    .res_o             (res)
  );

  kdlp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out)
  );

  // pack the result
  assign m_axis_tdata = {2'b00, out.long_seen, out.scan_state, out.toggle_pulse,
                         out.buzzer_off_pulse, out.buzzer_on_pulse};

endmodule
